FILE: rtl/core/icon_size_selection_parser_defines.svh
// assertion macros for the icon size selection parser checker
`ifndef ICON_SIZE_SELECTION_PARSER_DEFINES_SVH
`define ICON_SIZE_SELECTION_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define ISP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define ISP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/isp_pkg.sv
// shared types and constants for the icon size selection parser
`timescale 1ns / 1ps

package isp_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] PREF_SIZE_RESET = 32'd64;
    localparam logic [WORD_W-1:0] MIN_WORDS       = 32'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_WIDTH  = 4'b0010,
        PH_HEIGHT = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] height;
    } best_t;

endpackage

FILE: rtl/core/isp_select.sv
// candidate icon compare against the current best choice
`timescale 1ns / 1ps

module isp_select (
    input  isp_pkg::best_t             best,
    input  logic [isp_pkg::WORD_W-1:0] target_size,
    input  logic [isp_pkg::WORD_W-1:0] cand_width,
    input  logic [isp_pkg::WORD_W-1:0] cand_height,
    output logic [isp_pkg::WORD_W-1:0] cand_size,
    output logic                       take
);
    import isp_pkg::*;

    logic too_small;
    logic too_large;
    logic empty;
    logic bigger;
    logic smaller;

    always_comb begin
        cand_size = (cand_width > cand_height) ? cand_width : cand_height;
        too_small = best.size < target_size;
        too_large = best.size > target_size;
        empty     = (cand_width == '0) || (cand_height == '0);
        bigger    = too_small && (cand_size > best.size);
        smaller   = too_large && (cand_size >= target_size) && (cand_size < best.size);
        take      = !empty && (bigger || smaller || (best.size == '0));
    end

endmodule

FILE: rtl/core/icon_size_selection_parser.sv
// top level of the icon size selection parser
//
//   channel  direction  fields
//   s_       in         op, word
//   m_       out        found, icon_offset, icon_width, icon_height, icon_size
//   cfg_     in         target_size
//
// one item per cycle while the result is not stalled; an accepted item sits in the input
// register and, once the result register is free, goes through the header multiply and
// best-size compare into the parse state and, when it ends a parse, into the result register.
// a stalled result holds the result register and backs up into the input register.
// aresetn clears the parse state and the target size returns to 64.
`timescale 1ns / 1ps

module icon_size_selection_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [isp_pkg::WORD_W-1:0] s_word,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [isp_pkg::WORD_W-1:0] m_icon_offset,
    output logic [isp_pkg::WORD_W-1:0] m_icon_width,
    output logic [isp_pkg::WORD_W-1:0] m_icon_height,
    output logic [isp_pkg::WORD_W-1:0] m_icon_size,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [isp_pkg::WORD_W-1:0] cfg_target_size
);
    import isp_pkg::*;

    logic [WORD_W-1:0] pref_reg;

    logic              in_valid_reg;
    logic              in_op_reg;
    logic [WORD_W-1:0] in_word_reg;

    phase_t            phase_reg,     phase_next;
    logic [WORD_W-1:0] words_left_reg, words_left_next;
    logic [WORD_W-1:0] position_reg,  position_next;
    logic [WORD_W-1:0] hdr_width_reg, hdr_width_next;
    logic [WORD_W-1:0] skip_reg,      skip_next;
    best_t             best_reg,      best_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [WORD_W-1:0] offset_reg;
    logic [WORD_W-1:0] width_reg;
    logic [WORD_W-1:0] height_reg;
    logic [WORD_W-1:0] size_reg;

    logic                out_free;
    logic                proc_en;
    logic                emit;
    logic [2*WORD_W-1:0] product;
    logic [WORD_W-1:0]   cand_size;
    logic                take;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign proc_en   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || proc_en;

    assign product = {{WORD_W{1'b0}}, hdr_width_reg} * {{WORD_W{1'b0}}, in_word_reg};

    isp_select u_select (
        .best        (best_reg),
        .target_size (pref_reg),
        .cand_width  (hdr_width_reg),
        .cand_height (in_word_reg),
        .cand_size   (cand_size),
        .take        (take)
    );

    always_comb begin
        logic [WORD_W-1:0] wl;
        logic              icon_done;
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        position_next   = position_reg;
        hdr_width_next  = hdr_width_reg;
        skip_next       = skip_reg;
        best_next       = best_reg;
        emit            = 1'b0;
        icon_done       = 1'b0;
        wl              = words_left_reg - 1'b1;
        if (proc_en) begin
            if (in_op_reg == OP_START) begin
                best_next       = '0;
                position_next   = '0;
                hdr_width_next  = '0;
                skip_next       = '0;
                words_left_next = in_word_reg;
                if (in_word_reg < MIN_WORDS) begin
                    words_left_next = '0;
                    emit            = 1'b1;
                    phase_next      = PH_IDLE;
                end else begin
                    phase_next = PH_WIDTH;
                end
            end else if (phase_reg != PH_IDLE) begin
                words_left_next = wl;
                position_next   = position_reg + 1'b1;
                case (phase_reg)
                    PH_WIDTH: begin
                        hdr_width_next = in_word_reg;
                        phase_next     = PH_HEIGHT;
                    end
                    PH_HEIGHT: begin
                        if (product > {{WORD_W{1'b0}}, wl}) begin
                            skip_next = wl;
                        end else begin
                            skip_next = product[WORD_W-1:0];
                            if (take) begin
                                best_next.size   = cand_size;
                                best_next.offset = position_reg - 1'b1;
                                best_next.width  = hdr_width_reg;
                                best_next.height = in_word_reg;
                            end
                        end
                        if (skip_next == '0) begin
                            icon_done = 1'b1;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        skip_next = skip_reg - 1'b1;
                        if (skip_next == '0) begin
                            icon_done = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (icon_done) begin
                    if (wl == '0) begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end else if (wl < MIN_WORDS) begin
                        skip_next  = wl;
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_WIDTH;
                    end
                end
            end
        end
    end

    always_comb begin
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pref_reg       <= PREF_SIZE_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            words_left_reg <= '0;
            position_reg   <= '0;
            hdr_width_reg  <= '0;
            skip_reg       <= '0;
            best_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pref_reg <= cfg_target_size;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg  <= out_valid_next;
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            position_reg   <= position_next;
            hdr_width_reg  <= hdr_width_next;
            skip_reg       <= skip_next;
            best_reg       <= best_next;
        end
    end

    // item and result payloads
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg   <= s_op;
            in_word_reg <= s_word;
        end
        if (emit) begin
            found_reg  <= (best_next.size != '0);
            offset_reg <= (best_next.size != '0) ? best_next.offset : '0;
            width_reg  <= (best_next.size != '0) ? best_next.width  : '0;
            height_reg <= (best_next.size != '0) ? best_next.height : '0;
            size_reg   <= best_next.size;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_found       = found_reg;
    assign m_icon_offset = offset_reg;
    assign m_icon_width  = width_reg;
    assign m_icon_height = height_reg;
    assign m_icon_size   = size_reg;

endmodule

FILE: rtl/core/isp_checker.sv
// port checker for the icon size selection parser, bound to the top level
`timescale 1ns / 1ps
`include "icon_size_selection_parser_defines.svh"

module isp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [31:0] m_icon_offset,
    input logic [31:0] m_icon_width,
    input logic [31:0] m_icon_height,
    input logic [31:0] m_icon_size
);

    // stalled result holds
    `ISP_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_found, m_icon_offset, m_icon_width, m_icon_height, m_icon_size}), "result changed while stalled")

    // no icon means all fields zero
    `ISP_ASSERT_SAME(a_none_zero, aclk, aresetn, m_valid && !m_found, m_icon_offset == 32'd0 && m_icon_width == 32'd0 && m_icon_height == 32'd0 && m_icon_size == 32'd0, "nonzero fields without an icon")

    // a chosen icon is never empty
    `ISP_ASSERT_SAME(a_found_nonempty, aclk, aresetn, m_valid && m_found, m_icon_width != 32'd0 && m_icon_height != 32'd0, "chosen icon is empty")

    // size is the larger edge
    `ISP_ASSERT_SAME(a_size_max, aclk, aresetn, m_valid && m_found, m_icon_size >= m_icon_width && m_icon_size >= m_icon_height && (m_icon_size == m_icon_width || m_icon_size == m_icon_height), "size is not the larger edge")

endmodule

bind icon_size_selection_parser isp_checker u_isp_checker (.*);
